>>> design/dsort_pkg.sv
// shared constants, types and control codes for the decimal radix sorter
// no dependencies; imported by every other module of the block but dsort_ram
package dsort_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int VAL_W     = 31;
    localparam int NDIG      = 10;
    localparam int DIG_W     = 4;
    localparam int BCD_W     = NDIG * DIG_W;
    localparam int ADDR_W    = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int SEL_W     = $clog2(NDIG);
    localparam int PASS_W    = $clog2(NDIG);
    localparam int DCNT_W    = $clog2(NDIG + 1);
    localparam int STEP_W    = $clog2(VAL_W);
    localparam int WORD_W    = BCD_W + VAL_W;

    // one stored word: decimal digits next to the binary value
    typedef struct packed {
        logic [BCD_W-1:0] bcd;
        logic [VAL_W-1:0] val;
    } item_word_t;

    typedef enum logic [2:0] {
        CNT_NOP    = 3'd0,
        CNT_CLEAR  = 3'd1,
        CNT_INC    = 3'd2,
        CNT_PREFIX = 3'd3,
        CNT_DEC    = 3'd4
    } cnt_op_t;

    typedef struct packed {
        cnt_op_t          op;
        logic [SEL_W-1:0] sel;
    } cnt_ctrl_t;

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_CONV    = 7'b0000010,
        S_CLEAR   = 7'b0000100,
        S_COUNT   = 7'b0001000,
        S_PREFIX  = 7'b0010000,
        S_SCATTER = 7'b0100000,
        S_EMIT    = 7'b1000000
    } state_t;

endpackage

>>> design/dsort_ram.sv
// generic single-write, single-read memory with registered read data
// no dependencies
module dsort_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> design/dsort_bcd.sv
// binary to decimal converter, one shift-and-adjust step per cycle
// depends on dsort_pkg
module dsort_bcd import dsort_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [VAL_W-1:0] bin,
    output logic             done,
    output logic [BCD_W-1:0] bcd
);

    logic [VAL_W-1:0]  bin_reg, bin_next;
    logic [BCD_W-1:0]  bcd_reg, bcd_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic [BCD_W-1:0]  adj;

    // add three to every digit of five or more before the shift
    always_comb
    begin
        for (int i = 0; i < NDIG; i++)
        begin
            if (bcd_reg[i*DIG_W +: DIG_W] >= DIG_W'(5))
            begin
                adj[i*DIG_W +: DIG_W] = bcd_reg[i*DIG_W +: DIG_W] + DIG_W'(3);
            end
            else
            begin
                adj[i*DIG_W +: DIG_W] = bcd_reg[i*DIG_W +: DIG_W];
            end
        end
    end

    always_comb
    begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        step_next = step_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            bin_next  = bin;
            bcd_next  = '0;
            step_next = '0;
            run_next  = 1'b1;
        end
        else if (run_reg)
        begin
            bcd_next  = {adj[BCD_W-2:0], bin_reg[VAL_W-1]};
            bin_next  = {bin_reg[VAL_W-2:0], 1'b0};
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(VAL_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign done = done_reg;
    assign bcd  = bcd_reg;

endmodule

>>> design/dsort_cnt.sv
// bank of ten digit counters with a running prefix sum: clear, count, prefix, take
// depends on dsort_pkg
module dsort_cnt import dsort_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  cnt_ctrl_t         ctrl,
    output logic [ADDR_W-1:0] pos
);

    logic [CNT_W-1:0] counts_reg [NDIG];
    logic [CNT_W-1:0] counts_next [NDIG];
    logic [CNT_W-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0] cur;
    logic [CNT_W-1:0] dec;

    assign cur = counts_reg[ctrl.sel];
    assign dec = cur - CNT_W'(1);
    // slot of the next word with this digit, filled from the back
    assign pos = dec[ADDR_W-1:0];

    always_comb
    begin
        counts_next = counts_reg;
        acc_next    = acc_reg;
        unique case (ctrl.op)
            CNT_NOP:
            begin
            end
            CNT_CLEAR:
            begin
                for (int i = 0; i < NDIG; i++)
                begin
                    counts_next[i] = '0;
                end
                acc_next = '0;
            end
            CNT_INC:
            begin
                counts_next[ctrl.sel] = cur + CNT_W'(1);
            end
            CNT_PREFIX:
            begin
                acc_next              = acc_reg + cur;
                counts_next[ctrl.sel] = acc_reg + cur;
            end
            CNT_DEC:
            begin
                counts_next[ctrl.sel] = dec;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NDIG; i++)
            begin
                counts_reg[i] <= '0;
            end
            acc_reg <= '0;
        end
        else
        begin
            counts_reg <= counts_next;
            acc_reg    <= acc_next;
        end
    end

endmodule

>>> design/decimal_radix_sorter_top.sv
// decimal radix sorter: sequencer, two word memories and the shared units
// depends on dsort_pkg, dsort_ram, dsort_bcd, dsort_cnt
//
// Loads up to 64 non-negative 31-bit values, one per start, and sorts them in
// ascending order by base-10 least-significant-digit radix sort once a word
// arrives with last set or the 64th word is taken. Each load passes through the
// bit-serial binary-to-decimal converter; busy is high meanwhile. Sorting runs
// one pass per decimal digit of the largest value (0 to 10 passes); a pass reads
// every word twice, once to count and once to scatter, using the single read
// port of the word memory and the shared digit counter. The sorted words
// then come out on consecutive cycles, one per cycle, result_valid marking each
// and last_res the final one. The receiver cannot stall the results, so it
// must take every word in the cycle it is shown.
module decimal_radix_sorter_top import dsort_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [VAL_W-1:0] value,
    input  logic             last,
    output logic             result_valid,
    output logic [VAL_W-1:0] sorted_value,
    output logic             last_res
);

    state_t             state_reg, state_next;
    logic [VAL_W-1:0]   value_reg, value_next;
    logic               last_reg, last_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [DCNT_W-1:0]  digits_reg, digits_next;
    logic [PASS_W-1:0]  pass_reg, pass_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [SEL_W-1:0]   pidx_reg, pidx_next;
    logic               rd_valid_reg, rd_valid_next;
    logic               src_sel_reg, src_sel_next;
    logic               res_valid_reg, res_valid_next;
    logic [VAL_W-1:0]   res_value_reg, res_value_next;
    logic               res_last_reg, res_last_next;

    logic               accept;
    logic               conv_done;
    logic [BCD_W-1:0]   conv_bcd;
    logic [DCNT_W-1:0]  conv_nd;
    logic [DCNT_W-1:0]  digits_upd;
    logic               ram_we;
    logic               ram_wsel;
    logic [ADDR_W-1:0]  ram_waddr;
    item_word_t         ram_wdata;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [WORD_W-1:0]  rdata0, rdata1;
    item_word_t         rword;
    logic [SEL_W-1:0]   cur_digit;
    logic [CNT_W-1:0]   idx_dec;
    cnt_ctrl_t          cnt_ctrl;
    logic [ADDR_W-1:0]  cnt_pos;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    dsort_bcd u_bcd (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .bin   (value),
        .done  (conv_done),
        .bcd   (conv_bcd)
    );

    dsort_ram #(.WIDTH(WORD_W), .DEPTH(MAX_ITEMS)) u_ram0 (
        .clk   (clk),
        .we    (ram_we && !ram_wsel),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rdata0)
    );

    dsort_ram #(.WIDTH(WORD_W), .DEPTH(MAX_ITEMS)) u_ram1 (
        .clk   (clk),
        .we    (ram_we && ram_wsel),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rdata1)
    );

    dsort_cnt u_cnt (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (cnt_ctrl),
        .pos   (cnt_pos)
    );

    assign rword     = src_sel_reg ? item_word_t'(rdata1) : item_word_t'(rdata0);
    assign cur_digit = rword.bcd[pass_reg*DIG_W +: DIG_W];
    assign idx_dec   = idx_reg - CNT_W'(1);

    // number of decimal digits of the word being loaded
    always_comb
    begin
        conv_nd = '0;
        for (int i = 0; i < NDIG; i++)
        begin
            if (conv_bcd[i*DIG_W +: DIG_W] != '0)
            begin
                conv_nd = DCNT_W'(i + 1);
            end
        end
    end

    assign digits_upd = (conv_nd > digits_reg) ? conv_nd : digits_reg;

    always_comb
    begin
        state_next     = state_reg;
        value_next     = value_reg;
        last_next      = last_reg;
        count_next     = count_reg;
        digits_next    = digits_reg;
        pass_next      = pass_reg;
        idx_next       = idx_reg;
        pidx_next      = pidx_reg;
        rd_valid_next  = 1'b0;
        src_sel_next   = src_sel_reg;
        res_valid_next = 1'b0;
        res_value_next = res_value_reg;
        res_last_next  = 1'b0;
        ram_we         = 1'b0;
        ram_wsel       = src_sel_reg;
        ram_waddr      = cnt_pos;
        ram_wdata      = rword;
        ram_raddr      = idx_reg[ADDR_W-1:0];
        cnt_ctrl.op    = CNT_NOP;
        cnt_ctrl.sel   = cur_digit;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    value_next = value;
                    // a full store closes the set as if last were set
                    last_next  = last || (count_reg == CNT_W'(MAX_ITEMS - 1));
                    state_next = S_CONV;
                end
            end
            S_CONV:
            begin
                if (conv_done)
                begin
                    ram_we        = 1'b1;
                    ram_wsel      = src_sel_reg;
                    ram_waddr     = count_reg[ADDR_W-1:0];
                    ram_wdata.bcd = conv_bcd;
                    ram_wdata.val = value_reg;
                    count_next    = count_reg + CNT_W'(1);
                    digits_next   = digits_upd;
                    if (last_reg)
                    begin
                        pass_next = '0;
                        idx_next  = '0;
                        // all zero: nothing to sort
                        if (digits_upd == '0)
                        begin
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            state_next = S_CLEAR;
                        end
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_CLEAR:
            begin
                cnt_ctrl.op = CNT_CLEAR;
                idx_next    = '0;
                state_next  = S_COUNT;
            end
            S_COUNT:
            begin
                if (idx_reg < count_reg)
                begin
                    rd_valid_next = 1'b1;
                    idx_next      = idx_reg + CNT_W'(1);
                end
                if (rd_valid_reg)
                begin
                    cnt_ctrl.op = CNT_INC;
                    if (idx_reg == count_reg)
                    begin
                        pidx_next  = '0;
                        state_next = S_PREFIX;
                    end
                end
            end
            S_PREFIX:
            begin
                cnt_ctrl.op  = CNT_PREFIX;
                cnt_ctrl.sel = pidx_reg;
                if (pidx_reg == SEL_W'(NDIG - 1))
                begin
                    idx_next   = count_reg;
                    state_next = S_SCATTER;
                end
                else
                begin
                    pidx_next = pidx_reg + SEL_W'(1);
                end
            end
            S_SCATTER:
            begin
                // walk back to front so equal digits keep their order
                ram_raddr = idx_dec[ADDR_W-1:0];
                if (idx_reg != '0)
                begin
                    rd_valid_next = 1'b1;
                    idx_next      = idx_dec;
                end
                if (rd_valid_reg)
                begin
                    cnt_ctrl.op = CNT_DEC;
                    ram_we      = 1'b1;
                    ram_wsel    = !src_sel_reg;
                    if (idx_reg == '0)
                    begin
                        src_sel_next = !src_sel_reg;
                        if ((DCNT_W'(pass_reg) + DCNT_W'(1)) == digits_reg)
                        begin
                            idx_next   = '0;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            pass_next  = pass_reg + PASS_W'(1);
                            state_next = S_CLEAR;
                        end
                    end
                end
            end
            S_EMIT:
            begin
                if (idx_reg < count_reg)
                begin
                    rd_valid_next = 1'b1;
                    idx_next      = idx_reg + CNT_W'(1);
                end
                if (rd_valid_reg)
                begin
                    res_valid_next = 1'b1;
                    res_value_next = rword.val;
                    res_last_next  = (idx_reg == count_reg);
                    if (idx_reg == count_reg)
                    begin
                        count_next   = '0;
                        digits_next  = '0;
                        src_sel_next = 1'b0;
                        state_next   = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            last_reg      <= 1'b0;
            count_reg     <= '0;
            digits_reg    <= '0;
            pass_reg      <= '0;
            idx_reg       <= '0;
            pidx_reg      <= '0;
            rd_valid_reg  <= 1'b0;
            src_sel_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
            res_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            last_reg      <= last_next;
            count_reg     <= count_next;
            digits_reg    <= digits_next;
            pass_reg      <= pass_next;
            idx_reg       <= idx_next;
            pidx_reg      <= pidx_next;
            rd_valid_reg  <= rd_valid_next;
            src_sel_reg   <= src_sel_next;
            res_valid_reg <= res_valid_next;
            res_last_reg  <= res_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg     <= value_next;
        res_value_reg <= res_value_next;
    end

    assign result_valid = res_valid_reg;
    assign sorted_value = res_value_reg;
    assign last_res     = res_last_reg;

    // a result word only follows a cycle of the emit phase
    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(state_reg == S_EMIT))
        else $error("result word outside emit phase");

    a_last_with_valid: assert property (@(posedge clk) disable iff (!rst_n)
        last_res |-> result_valid)
        else $error("last_res without result word");

    a_store_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (count_reg < CNT_W'(MAX_ITEMS)))
        else $error("store full while idle");

    a_conv_done_in_conv: assert property (@(posedge clk) disable iff (!rst_n)
        conv_done |-> (state_reg == S_CONV))
        else $error("converter finished outside load");

    a_pass_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCATTER) |-> (DCNT_W'(pass_reg) < digits_reg))
        else $error("pass beyond digit count of largest word");

endmodule

>>> verif/decimal_radix_sorter_top_test.sv
`timescale 1ns / 1ps
// self-checking bench for decimal_radix_sorter_top: a directed table, then random sets
// depends on dsort_pkg and the design sources; words checked against an in-bench radix sort
module decimal_radix_sorter_top_test;
    import dsort_pkg::*;

    localparam int RADIX      = 10;
    localparam int MAX_PASSES = 10;
    localparam int DIR_ROWS   = 23;
    localparam int RAND_WORDS = 77;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             last;
    } sorted_word_t;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             last;
        logic             typed;
        logic [VAL_W-1:0] want;
    } dir_row_t;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic [VAL_W-1:0] value;
    logic             last;
    logic             result_valid;
    logic [VAL_W-1:0] sorted_value;
    logic             last_res;

    sorted_word_t     sorted_q[$];
    sorted_word_t     fresh_q[$];
    logic [VAL_W-1:0] set_vals[$];
    logic [VAL_W-1:0] set_max;
    int               mismatches;
    bit               gaps_on;

    // typed rows are one-word sets, so the single sorted word is the input itself
    dir_row_t dir_rows [0:DIR_ROWS-1] = '{
        '{31'd0,          1'b1, 1'b1, 31'd0},
        '{31'h7fffffff,   1'b1, 1'b1, 31'h7fffffff},
        '{31'd9,          1'b1, 1'b1, 31'd9},
        '{31'd10,         1'b1, 1'b1, 31'd10},
        '{31'd1000000000, 1'b1, 1'b1, 31'd1000000000},
        // largest value needs the tenth pass at place value 10^9
        '{31'h7fffffff,   1'b0, 1'b0, 31'd0},
        '{31'd0,          1'b0, 1'b0, 31'd0},
        '{31'd1000000000, 1'b1, 1'b0, 31'd0},
        '{31'd170,        1'b0, 1'b0, 31'd0},
        '{31'd45,         1'b0, 1'b0, 31'd0},
        '{31'd75,         1'b0, 1'b0, 31'd0},
        '{31'd90,         1'b0, 1'b0, 31'd0},
        '{31'd802,        1'b0, 1'b0, 31'd0},
        '{31'd24,         1'b0, 1'b0, 31'd0},
        '{31'd2,          1'b0, 1'b0, 31'd0},
        '{31'd66,         1'b1, 1'b0, 31'd0},
        '{31'd5,          1'b0, 1'b0, 31'd0},
        '{31'd5,          1'b0, 1'b0, 31'd0},
        '{31'd5,          1'b1, 1'b0, 31'd0},
        '{31'd999999999,  1'b0, 1'b0, 31'd0},
        '{31'd99999999,   1'b0, 1'b0, 31'd0},
        '{31'd9999999,    1'b0, 1'b0, 31'd0},
        '{31'd999999,     1'b1, 1'b0, 31'd0}
    };

    decimal_radix_sorter_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .value        (value),
        .last         (last),
        .result_valid (result_valid),
        .sorted_value (sorted_value),
        .last_res     (last_res)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string what, input logic [VAL_W-1:0] got,
                                   input logic [VAL_W-1:0] want);
        $display("%0t: %s: got %0d, want %0d", $time, what, got, want);
        mismatches++;
    endtask

    // stores one word; on the closing word of a set, radix sorts it into fresh_q
    function automatic void predict_word(input logic [VAL_W-1:0] v, input logic l);
        logic [VAL_W-1:0] work  [0:MAX_ITEMS-1];
        logic [VAL_W-1:0] spill [0:MAX_ITEMS-1];
        int               tally [0:RADIX-1];
        longint           place;
        int               n;
        int               pass;
        int               d;
        int               k;
        set_vals.push_back(v);
        if (set_vals.size() == 1 || v > set_max)
            set_max = v;
        if (!l && set_vals.size() < MAX_ITEMS)
            return;
        n = set_vals.size();
        for (k = 0; k < n; k++)
            work[k] = set_vals[k];
        place = 1;
        for (pass = 0; pass < MAX_PASSES && (longint'(set_max) / place) != 0; pass++)
        begin
            for (d = 0; d < RADIX; d++)
                tally[d] = 0;
            for (k = 0; k < n; k++)
                tally[(longint'(work[k]) / place) % RADIX]++;
            for (d = 1; d < RADIX; d++)
                tally[d] += tally[d-1];
            // back to front keeps equal digits in order
            for (k = n - 1; k >= 0; k--)
            begin
                d = (longint'(work[k]) / place) % RADIX;
                tally[d]--;
                spill[tally[d]] = work[k];
            end
            for (k = 0; k < n; k++)
                work[k] = spill[k];
            place *= RADIX;
        end
        for (k = 0; k < n; k++)
            fresh_q.push_back('{value: work[k], last: (k == n - 1)});
        set_vals.delete();
        set_max = '0;
    endfunction

    task automatic send_word(input logic [VAL_W-1:0] v, input logic l, input bit use_model);
        while (gaps_on && $urandom_range(0, 99) < 37)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        value <= v;
        last  <= l;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_word(v, l);
        while (fresh_q.size() != 0)
        begin
            if (use_model)
                sorted_q.push_back(fresh_q[0]);
            void'(fresh_q.pop_front());
        end
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 4))
            0: return VAL_W'($urandom);
            1: return VAL_W'($urandom_range(0, 99));
            2: return VAL_W'($urandom_range(0, 9));
            3: return VAL_W'($urandom_range(0, 10 ** $urandom_range(1, 9)));
            default: return VAL_W'(31'h7fffffff - $urandom_range(0, 3));
        endcase
    endfunction

    always @(posedge clk)
    begin : watch_results
        sorted_word_t w;
        if (rst_n && result_valid)
        begin
            if (sorted_q.size() == 0)
                report_mismatch("sorted word with nothing expected", sorted_value, '0);
            else
            begin
                w = sorted_q.pop_front();
                if (sorted_value !== w.value)
                    report_mismatch("sorted_value", sorted_value, w.value);
                if (last_res !== w.last)
                    report_mismatch("last_res", VAL_W'(last_res), VAL_W'(w.last));
            end
        end
    end

    initial
    begin : stimulus
        int k;
        int n;
        int words;
        bit full_done;
        bit full_set;
        clk        = 1'b0;
        rst_n      = 1'b0;
        start      = 1'b0;
        value      = '0;
        last       = 1'b0;
        set_max    = '0;
        mismatches = 0;
        gaps_on    = 1'b1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        for (k = 0; k < DIR_ROWS; k++)
        begin
            send_word(dir_rows[k].value, dir_rows[k].last, !dir_rows[k].typed);
            if (dir_rows[k].typed)
                sorted_q.push_back('{value: dir_rows[k].want, last: 1'b1});
        end

        words     = 0;
        full_done = 1'b0;
        while (words < RAND_WORDS)
        begin
            // the first set fills the store with last never set
            full_set = !full_done;
            if (full_set)
                n = MAX_ITEMS;
            else if ($urandom_range(0, 9) == 0)
                n = $urandom_range(9, 40);
            else
                n = $urandom_range(1, 8);
            if (!full_set && n > RAND_WORDS - words)
                n = RAND_WORDS - words;
            for (k = 0; k < n; k++)
            begin
                gaps_on = (words < 10 || words >= 45);
                send_word(pick_value(), (k == n - 1) && !full_set, 1'b1);
                words++;
            end
            if (full_set)
                full_done = 1'b1;
        end
        start <= 1'b0;

        while (sorted_q.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin : run_limit
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
